// File: design/three_level_priority_stable_sort_defines.svh
// Assertion macros used by the checker file of the priority sort block.
`ifndef THREE_LEVEL_PRIORITY_STABLE_SORT_DEFINES_SVH
`define THREE_LEVEL_PRIORITY_STABLE_SORT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TLPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TLPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tlps_pkg.sv
// Shared types and constants of the three-level priority sort block.
package tlps_pkg;

  localparam int DEPTH         = 64;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int IDX_W         = $clog2(DEPTH);
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int PRI_W         = 2;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PRI_W-1:0] PRI_NONE  = 2'd0;
  localparam logic [PRI_W-1:0] PRI_FIRST = 2'd1;
  localparam logic [PRI_W-1:0] PRI_LAST  = 2'd3;

  typedef struct packed {
    logic [PRI_W-1:0]         priority_req;
    logic [PAYLOAD_WIDTH-1:0] payload;
    logic                     last_in;
  } in_word_t;

  typedef struct packed {
    logic [PAYLOAD_WIDTH-1:0] sorted_payload;
    logic [PRI_W-1:0]         sorted_priority;
    logic                     last_out;
  } out_word_t;

  // Command passed from the front end to the back end.
  typedef struct packed {
    logic                     write;
    logic                     flush;
    logic [PRI_W-1:0]         pri;
    logic [PAYLOAD_WIDTH-1:0] payload;
  } cmd_t;

endpackage

// File: design/tlps_front.sv
// Front end: classifies incoming words and turns them into store and flush commands.
module tlps_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tlps_pkg::in_word_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output tlps_pkg::cmd_t    cmd
);

  logic [tlps_pkg::CNT_W-1:0] count_r;
  logic [tlps_pkg::CNT_W-1:0] count_nxt;
  logic                       keep;
  logic                       accept;

  // An entry is kept when its priority is valid and the list still has room.
  assign keep   = (in_data.priority_req != tlps_pkg::PRI_NONE) &&
                  (count_r < tlps_pkg::CNT_W'(tlps_pkg::DEPTH));
  assign in_ready  = cmd_ready;
  assign accept    = in_valid && in_ready;
  assign cmd_valid = accept && (keep || in_data.last_in);

  assign cmd.write   = keep;
  assign cmd.flush   = in_data.last_in;
  assign cmd.pri     = in_data.priority_req;
  assign cmd.payload = in_data.payload;

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (in_data.last_in) begin
        count_nxt = '0;
      end else if (keep) begin
        count_nxt = count_r + tlps_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// File: design/tlps_queue.sv
// Short command queue that decouples the front end from the back end.
module tlps_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  tlps_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tlps_pkg::cmd_t pop_cmd
);

  tlps_pkg::cmd_t              entry_r [tlps_pkg::QUEUE_DEPTH];
  logic [tlps_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [tlps_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [tlps_pkg::QCNT_W-1:0] fill_r;
  logic                        push;
  logic                        pop;

  assign push_ready = (fill_r != tlps_pkg::QCNT_W'(tlps_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == tlps_pkg::QPTR_W'(tlps_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + tlps_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == tlps_pkg::QPTR_W'(tlps_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + tlps_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + tlps_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - tlps_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// File: design/tlps_back.sv
// Back end: entry store, three-pass priority scan and output register.
module tlps_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  tlps_pkg::cmd_t      cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output tlps_pkg::out_word_t out_data
);

  logic [tlps_pkg::PAYLOAD_WIDTH-1:0] pay_mem [tlps_pkg::DEPTH];
  logic [tlps_pkg::PRI_W-1:0]         pri_mem [tlps_pkg::DEPTH];

  logic [tlps_pkg::CNT_W-1:0]         fill_r;
  logic [tlps_pkg::CNT_W-1:0]         fill_upd;
  logic [tlps_pkg::CNT_W-1:0]         total_r;
  logic [tlps_pkg::CNT_W-1:0]         emit_cnt_r;
  logic                               scan_r;
  logic [tlps_pkg::PRI_W-1:0]         pass_r;
  logic [tlps_pkg::IDX_W-1:0]         idx_r;

  logic                               rd_v_r;
  logic [tlps_pkg::PAYLOAD_WIDTH-1:0] rd_pay_r;
  logic [tlps_pkg::PRI_W-1:0]         rd_pri_r;
  logic [tlps_pkg::PRI_W-1:0]         rd_tag_r;

  logic                               out_valid_r;
  tlps_pkg::out_word_t                out_r;

  logic                               take;
  logic                               out_free;
  logic                               s1_match;
  logic                               s1_go;
  logic                               issue;
  logic                               idx_end;
  logic                               emit;

  // Commands wait while a scan is still reading the store.
  assign cmd_ready = !scan_r && !rd_v_r;
  assign take      = cmd_valid && cmd_ready;
  assign fill_upd  = fill_r + tlps_pkg::CNT_W'(cmd.write);

  assign out_free = !out_valid_r || out_ready;
  assign s1_match = rd_v_r && (rd_pri_r == rd_tag_r);
  assign s1_go    = rd_v_r && (!s1_match || out_free);
  assign issue    = scan_r && (!rd_v_r || s1_go);
  assign idx_end  = ({1'b0, idx_r} == (total_r - tlps_pkg::CNT_W'(1)));
  assign emit     = s1_go && s1_match;

  always_ff @(posedge clk) begin
    if (take && cmd.write) begin
      pay_mem[fill_r[tlps_pkg::IDX_W-1:0]] <= cmd.payload;
      pri_mem[fill_r[tlps_pkg::IDX_W-1:0]] <= cmd.pri;
    end
    if (issue) begin
      rd_pay_r <= pay_mem[idx_r];
      rd_pri_r <= pri_mem[idx_r];
      rd_tag_r <= pass_r;
    end
    if (emit) begin
      out_r.sorted_payload  <= rd_pay_r;
      out_r.sorted_priority <= rd_pri_r;
      out_r.last_out        <= (emit_cnt_r == (total_r - tlps_pkg::CNT_W'(1)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      total_r     <= '0;
      emit_cnt_r  <= '0;
      scan_r      <= 1'b0;
      pass_r      <= tlps_pkg::PRI_FIRST;
      idx_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        if (cmd.flush) begin
          fill_r     <= '0;
          total_r    <= fill_upd;
          emit_cnt_r <= '0;
          scan_r     <= (fill_upd != '0);
          pass_r     <= tlps_pkg::PRI_FIRST;
          idx_r      <= '0;
        end else begin
          fill_r <= fill_upd;
        end
      end

      if (issue) begin
        if (idx_end) begin
          idx_r <= '0;
          if (pass_r == tlps_pkg::PRI_LAST) begin
            scan_r <= 1'b0;
          end else begin
            pass_r <= pass_r + tlps_pkg::PRI_W'(1);
          end
        end else begin
          idx_r <= idx_r + tlps_pkg::IDX_W'(1);
        end
      end

      if (issue) begin
        rd_v_r <= 1'b1;
      end else if (s1_go) begin
        rd_v_r <= 1'b0;
      end

      if (emit) begin
        emit_cnt_r  <= emit_cnt_r + tlps_pkg::CNT_W'(1);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: design/three_level_priority_stable_sort.sv
// Top level of the three-level priority stable sort block.
// Loading takes one input word per cycle while the command queue has room; a kept entry is
// stored once the back end takes its command. After the last word, emission scans the N kept
// entries three times, one store read per cycle unless a waiting result holds the scan.
// Emission is bound by the single read port of the entry store; a new list is stored once
// the scan is done. Synchronous active-low reset empties the list and the queue.
module three_level_priority_stable_sort (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tlps_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tlps_pkg::out_word_t out_data
);

  // Command path from the front end through the queue into the back end.
  logic           f_valid;
  logic           f_ready;
  tlps_pkg::cmd_t f_cmd;
  logic           b_valid;
  logic           b_ready;
  tlps_pkg::cmd_t b_cmd;

  // The front end drops words with an invalid priority or that arrive once the
  // list is full, and only forwards words that store an entry or close the list.
  tlps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  // The queue lets the front end keep taking words while the back end is
  // held, for example during a scan, until its two entries are full.
  tlps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_cmd    (b_cmd)
  );

  // The back end writes entries in arrival order and, on a flush, walks the
  // store once per priority level, which keeps the order stable within a level.
  // Its output register lets the scan pass other priorities while a result waits downstream.
  tlps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd       (b_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: design/tlps_checker.sv
// Port-level checker for the priority sort block and its bind statement.
`include "three_level_priority_stable_sort_defines.svh"

module tlps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input tlps_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input tlps_pkg::out_word_t out_data
);

  `TLPS_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data), "input word changed while stalled")
  `TLPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")
  `TLPS_ASSERT_NOW(a_pri_valid, out_valid, out_data.sorted_priority != tlps_pkg::PRI_NONE, "result word carries priority zero")
  `TLPS_ASSERT_NEXT(a_pri_order, out_valid && out_ready && !out_data.last_out, !out_valid || (out_data.sorted_priority >= $past(out_data.sorted_priority)), "priority went down within a list")
  `TLPS_ASSERT_NOW(a_reset_idle, $past(!rst_n), !out_valid, "result word valid right after reset")

endmodule

bind three_level_priority_stable_sort tlps_checker u_tlps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: test/tb.sv
// Self-checking testbench for the three-level priority stable sort block.
`timescale 1ns / 100ps

module tb;

  // The package names the first and last priority only; the middle one is local here.
  localparam logic [tlps_pkg::PRI_W-1:0] PRI_MIDDLE = 2'd2;

  // Number of input words the whole run aims for before the random phase stops.
  localparam int RANDOM_WORD_TARGET = 420;
  // Length of the long receiver hold-off in the back-pressure test, in cycles.
  localparam int HOLD_OFF_CYCLES = 400;
  // Quiet cycles after the last expected word, sized from three passes over a full store plus margin.
  localparam int DRAIN_CYCLES = 3 * tlps_pkg::DEPTH + 20;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  tlps_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_ready;
  tlps_pkg::out_word_t out_data;

  three_level_priority_stable_sort u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Entries of the list being loaded, in arrival order, as the block should keep them.
  tlps_pkg::in_word_t  kept_entries_q[$];
  // Sorted words that the block still owes us, oldest first.
  tlps_pkg::out_word_t sorted_words_q[$];

  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned lists_closed;
  int unsigned empty_lists;
  int unsigned mismatches;

  // Idling controls. A steady side never idles; a hold request makes the receiver
  // refuse results for a long, counted stretch.
  bit tx_steady;
  bit rx_steady;
  bit rx_hold_request;

  tlps_pkg::out_word_t want_word;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous fixed time limit on the whole run.
  initial begin
    #5_000_000;
    $display("timeout with %0d sorted words outstanding", sorted_words_q.size());
    $display("status: fail");
    $finish;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap(bit steady);
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic tlps_pkg::in_word_t make_word(logic [tlps_pkg::PRI_W-1:0] pri,
                                                   logic [tlps_pkg::PAYLOAD_WIDTH-1:0] pay,
                                                   logic last);
    tlps_pkg::in_word_t w;
    w.priority_req = pri;
    w.payload      = pay;
    w.last_in      = last;
    return w;
  endfunction

  // A random entry: mostly valid priorities, with a share of dropped priority-zero entries.
  function automatic tlps_pkg::in_word_t random_entry(int unsigned drop_pct, logic last);
    logic [tlps_pkg::PRI_W-1:0] pri;
    if ($urandom_range(0, 99) < drop_pct) pri = tlps_pkg::PRI_NONE;
    else pri = tlps_pkg::PRI_W'($urandom_range(tlps_pkg::PRI_FIRST, tlps_pkg::PRI_LAST));
    return make_word(pri, tlps_pkg::PAYLOAD_WIDTH'($urandom), last);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Track one accepted entry. On the closing word, the kept entries are laid out in
  // priority order, arrival order within a priority, and the final one is flagged.
  task automatic predict_sorted(tlps_pkg::in_word_t w);
    tlps_pkg::out_word_t o;
    int                  pri;
    int                  total;
    int                  emitted;
    // Priority zero is dropped, and so is anything once the store holds DEPTH entries.
    if (w.priority_req != tlps_pkg::PRI_NONE && kept_entries_q.size() < tlps_pkg::DEPTH)
      kept_entries_q.push_back(w);
    if (w.last_in) begin
      total   = kept_entries_q.size();
      emitted = 0;
      for (pri = tlps_pkg::PRI_FIRST; pri <= tlps_pkg::PRI_LAST; pri++) begin
        foreach (kept_entries_q[i]) begin
          if (int'(kept_entries_q[i].priority_req) == pri) begin
            emitted++;
            o.sorted_payload  = kept_entries_q[i].payload;
            o.sorted_priority = kept_entries_q[i].priority_req;
            o.last_out        = (emitted == total);
            sorted_words_q.push_back(o);
          end
        end
      end
      // A list with nothing kept produces no words at all.
      if (total == 0) empty_lists++;
      lists_closed++;
      kept_entries_q.delete();
    end
  endtask

  // Offer one word and hold it until the block takes it. Valid is only lowered when a
  // gap really follows, so back-to-back words keep valid high across the edge.
  task automatic send_word(tlps_pkg::in_word_t w);
    int unsigned gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_sorted(w);
    words_sent++;
  endtask

  // A whole random list; the closing flag sits on the final word.
  task automatic send_random_list(int unsigned len, int unsigned drop_pct);
    for (int unsigned n = 1; n <= len; n++)
      send_word(random_entry(drop_pct, n == len));
  endtask

  // Field extremes and every priority in one list, with a dropped entry in the middle.
  task automatic test_field_extremes();
    send_word(make_word(tlps_pkg::PRI_LAST,  32'hFFFF_FFFF, 1'b0));
    send_word(make_word(tlps_pkg::PRI_FIRST, 32'h0000_0000, 1'b0));
    send_word(make_word(PRI_MIDDLE,          32'hAAAA_AAAA, 1'b0));
    send_word(make_word(tlps_pkg::PRI_NONE,  32'hDEAD_BEEF, 1'b0));
    send_word(make_word(PRI_MIDDLE,          32'h5555_5555, 1'b0));
    send_word(make_word(tlps_pkg::PRI_FIRST, 32'h8000_0001, 1'b0));
    send_word(make_word(tlps_pkg::PRI_LAST,  32'h7FFF_FFFE, 1'b1));
  endtask

  // One-entry lists of each priority: the only word is also the final one.
  task automatic test_single_entry_lists();
    send_word(make_word(tlps_pkg::PRI_FIRST, 32'h0000_0001, 1'b1));
    send_word(make_word(PRI_MIDDLE,          32'h0000_0002, 1'b1));
    send_word(make_word(tlps_pkg::PRI_LAST,  32'hFFFF_FFFF, 1'b1));
  endtask

  // The closing word carries priority zero: it is dropped but emission still starts.
  task automatic test_dropped_closing_word();
    send_word(make_word(tlps_pkg::PRI_LAST,  32'h1234_5678, 1'b0));
    send_word(make_word(tlps_pkg::PRI_FIRST, 32'h9ABC_DEF0, 1'b0));
    send_word(make_word(tlps_pkg::PRI_NONE,  32'hFFFF_FFFF, 1'b1));
  endtask

  // Lists that keep nothing must produce no words and leave the block usable.
  task automatic test_empty_lists();
    send_word(make_word(tlps_pkg::PRI_NONE, 32'h0000_0000, 1'b1));
    send_word(make_word(tlps_pkg::PRI_NONE, 32'hFFFF_FFFF, 1'b1));
    send_word(make_word(PRI_MIDDLE,         32'hCAFE_F00D, 1'b1));
  endtask

  // Stability: equal priorities must come out in arrival order.
  task automatic test_equal_priorities();
    for (int n = 0; n < 5; n++)
      send_word(make_word(tlps_pkg::PRI_LAST, tlps_pkg::PAYLOAD_WIDTH'(32'h100 + n), n == 4));
  endtask

  // Fill the store exactly, then overfill it so that the closing word itself is dropped.
  task automatic test_store_full();
    for (int n = 1; n <= tlps_pkg::DEPTH; n++)
      send_word(random_entry(0, n == tlps_pkg::DEPTH));
    for (int n = 1; n <= tlps_pkg::DEPTH + 4; n++)
      send_word(random_entry(0, n == tlps_pkg::DEPTH + 4));
  endtask

  // The receiver stops for a long stretch while lists keep coming, so the block fills up
  // and must stall its input.
  task automatic test_receiver_hold_off();
    rx_hold_request = 1'b1;
    tx_steady       = 1'b1;
    repeat (3) send_random_list(16, 10);
    tx_steady = 1'b0;
  endtask

  // Mostly short random lists, some medium and a few near the store depth that may
  // overfill it, plus lone dropped closing words as noise. Some lists run with no idling.
  task automatic test_random_lists();
    int unsigned roll;
    int unsigned len;
    while (words_sent < RANDOM_WORD_TARGET) begin
      tx_steady = ($urandom_range(0, 99) < 15);
      rx_steady = ($urandom_range(0, 99) < 15);
      roll = $urandom_range(0, 99);
      if (roll < 6) len = 1;
      else if (roll < 80) len = $urandom_range(2, 8);
      else if (roll < 95) len = $urandom_range(9, 30);
      else len = $urandom_range(tlps_pkg::DEPTH - 4, tlps_pkg::DEPTH + 6);
      if ($urandom_range(0, 99) < 5)
        send_word(make_word(tlps_pkg::PRI_NONE, tlps_pkg::PAYLOAD_WIDTH'($urandom), 1'b1));
      else send_random_list(len, 10);
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Receiver: random gaps on out_ready, or a long hold-off counted here when asked for.
  initial begin
    int unsigned hold_left;
    int unsigned gap_left;
    out_ready = 1'b0;
    hold_left = 0;
    gap_left  = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_request) begin
        rx_hold_request = 1'b0;
        hold_left       = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        gap_left = pick_gap(rx_steady);
      end
    end
  end

  // Every accepted result word is compared field by field with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (sorted_words_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word payload %h priority %0d last %b",
                                  out_data.sorted_payload, out_data.sorted_priority,
                                  out_data.last_out));
      end else begin
        want_word = sorted_words_q.pop_front();
        words_checked++;
        if (out_data.sorted_payload !== want_word.sorted_payload)
          report_mismatch($sformatf("sorted_payload %h, wanted %h",
                                    out_data.sorted_payload, want_word.sorted_payload));
        if (out_data.sorted_priority !== want_word.sorted_priority)
          report_mismatch($sformatf("sorted_priority %0d, wanted %0d",
                                    out_data.sorted_priority, want_word.sorted_priority));
        if (out_data.last_out !== want_word.last_out)
          report_mismatch($sformatf("last_out %b, wanted %b (payload %h)",
                                    out_data.last_out, want_word.last_out,
                                    want_word.sorted_payload));
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    tx_steady       = 1'b0;
    rx_steady       = 1'b0;
    rx_hold_request = 1'b0;
    words_sent      = 0;
    words_checked   = 0;
    lists_closed    = 0;
    empty_lists     = 0;
    mismatches      = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_single_entry_lists();
    test_dropped_closing_word();
    test_empty_lists();
    test_equal_priorities();
    test_store_full();
    test_receiver_hold_off();
    test_random_lists();

    // All stimulus is in; let the receiver drain everything that is still owed.
    in_valid <= 1'b0;
    rx_steady = 1'b1;
    while (sorted_words_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input words in %0d lists (%0d empty), %0d sorted words checked",
             words_sent, lists_closed, empty_lists, words_checked);
    $display("included store overflow, dropped closing words and a %0d-cycle receiver stall",
             HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
